@@ src/mtvb_pkg.sv @@
// Shared types and constants of the morph target vertex blend.
// No dependencies.
`default_nettype none
package mtvb_pkg;
  localparam int unsigned TARGET_SLOTS_DEF = 4;
  localparam int unsigned COMPONENTS_DEF   = 4;
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned ACC_W            = 48;
  localparam int unsigned CFG_IDX_W        = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd6;

  // shared-unit operations
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;
endpackage
`default_nettype wire

@@ src/mtvb_alu.sv @@
// Shared iterative unit: 64-bit unsigned multiply (one 32x32 partial product per
// cycle) and 64/64 restoring divide (one quotient bit per cycle).
// Depends on mtvb_pkg.
`default_nettype none
module mtvb_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mtvb_pkg::alu_ctl_t ctl,
  input  wire logic [63:0]       a,
  input  wire logic [63:0]       b,
  output logic [63:0]            result,
  output logic                   done
);
  import mtvb_pkg::*;

  alu_op_t     op;
  logic [6:0]  cnt;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] acc;
  logic [63:0] rem;
  logic        busy;
  logic [63:0] pp;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  // partial product of the two selected 32-bit halves
  always_comb begin
    pp = 64'({32'd0, (cnt[1] ? opa[63:32] : opa[31:0])} *
             {32'd0, (cnt[0] ? opb[63:32] : opb[31:0])});
    rem_sh  = {rem, acc[63]};
    rem_sub = rem_sh - {1'b0, opb};
  end

  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_NONE;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        cnt  <= '0;
        opa  <= a;
        opb  <= b;
        rem  <= '0;
        acc  <= (ctl.op == OP_DIV) ? a : 64'd0;
      end else if (busy) begin
        unique case (op)
          OP_MUL: begin
            // weights: lo*lo, lo*hi<<32, hi*lo<<32, hi*hi dropped (mod 2^64)
            case (cnt[1:0])
              2'd0:    acc <= acc + pp;
              2'd1:    acc <= acc + {pp[31:0], 32'd0};
              2'd2:    acc <= acc + {pp[31:0], 32'd0};
              default: acc <= acc;
            endcase
            cnt <= cnt + 7'd1;
            if (cnt == 7'd3) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_DIV: begin
            if (!rem_sub[64]) begin
              rem <= rem_sub[63:0];
              acc <= {acc[62:0], 1'b1};
            end else begin
              rem <= rem_sh[63:0];
              acc <= {acc[62:0], 1'b0};
            end
            cnt <= cnt + 7'd1;
            if (cnt == 7'd63) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

@@ src/morph_target_vertex_blend.sv @@
// A request of an inactive slot is accepted and then finished; a request of an
// active slot also runs four multiplies in the shared unit between the two.
// A final request adds an output state and, under normalization with an active
// slot, first scaling steps, one square per used component, a square root and
// one divide per used component. One request at a time; ready only when
// idle, and the output state waits while the previous result is still unaccepted.
// Reset (rst, synchronous): weights 0, mask 0, normalize 0, count 3, accumulators 0.
`default_nettype none
module morph_target_vertex_blend #(
  parameter int unsigned TARGET_SLOTS = mtvb_pkg::TARGET_SLOTS_DEF,
  parameter int unsigned COMPONENTS   = mtvb_pkg::COMPONENTS_DEF,
  parameter int unsigned FRAC_BITS    = mtvb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mtvb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // base_x, base_y, base_z, base_w, target_x, target_y, target_z, target_w
  input  wire logic [255:0]                    s_tdata,
  // target_slot
  input  wire logic [1:0]                      s_tuser,
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // out_x, out_y, out_z, out_w
  output logic [127:0]                         m_tdata,
  // zero_length
  output logic                                 m_tuser
);
  import mtvb_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_MUL   = 12'b000000000010,
    ST_MWAIT = 12'b000000000100,
    ST_FIN   = 12'b000000001000,
    ST_NORM  = 12'b000000010000,
    ST_SQ    = 12'b000000100000,
    ST_SQW   = 12'b000001000000,
    ST_ROOT  = 12'b000010000000,
    ST_DIV   = 12'b000100000000,
    ST_DWAIT = 12'b001000000000,
    ST_OUT   = 12'b010000000000,
    ST_HOLD  = 12'b100000000000
  } state_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  state_t state;
  logic [31:0] weight [4];
  logic [3:0]  enable_mask;
  logic        normalize;
  logic [2:0]  component_count;
  logic signed [ACC_W-1:0] acc [4];
  logic        first_item;
  logic signed [31:0] base [4];
  logic signed [31:0] tgt [4];
  logic [1:0]  slot;
  logic        last;
  logic [1:0]  comp;
  logic        neg_prod;
  logic [63:0] mag [4];
  logic [63:0] sum;
  logic [63:0] root_rem;
  logic [63:0] root_res;
  logic [63:0] root_bit;
  logic [2:0]  ncomp;
  logic [31:0] res [4];
  logic        zero_len;
  logic [63:0] mx;

  alu_ctl_t    alu_ctl;
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic [63:0] alu_res;
  logic        alu_done;

  mtvb_alu u_alu (
    .clk(clk), .rst(rst), .ctl(alu_ctl), .a(alu_a), .b(alu_b),
    .result(alu_res), .done(alu_done)
  );

  // slot activity
  function automatic logic active(input logic [1:0] s, input logic [3:0] m,
                                  input logic [31:0] w);
    active = (32'(s) < TARGET_SLOTS) && m[s] && (w != 32'd0);
  endfunction

  logic any_active;
  logic cur_active;
  always_comb begin
    any_active = 1'b0;
    for (int i = 0; i < 4; i++)
      if (active(2'(i), enable_mask, weight[i])) any_active = 1'b1;
    cur_active = active(slot, enable_mask, weight[slot]);
    if (component_count < 3'd2) ncomp = 3'd2;
    else if (32'(component_count) > COMPONENTS) ncomp = 3'(COMPONENTS);
    else ncomp = component_count;
  end

  // current difference magnitude and weight magnitude for the shared multiplier
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic [31:0] w_mag;
  logic signed [31:0] w_cur;
  always_comb begin
    w_cur    = weight[slot];
    diff     = 33'(tgt[comp]) - 33'(base[comp]);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    w_mag    = w_cur[31] ? 32'(-w_cur) : w_cur;
  end

  // rounding, 48-bit saturation and accumulate for a finished product
  logic signed [65:0] prod_s;
  logic signed [65:0] term;
  logic signed [ACC_W-1:0] term48;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_new;
  always_comb begin
    prod_s = neg_prod ? -$signed({2'b00, alu_res}) : $signed({2'b00, alu_res});
    term   = (prod_s + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (term > 66'(ACC_MAX)) term48 = ACC_MAX;
    else if (term < 66'(ACC_MIN)) term48 = ACC_MIN;
    else term48 = term[ACC_W-1:0];
    acc_sum = (ACC_W+1)'(acc[comp]) + (ACC_W+1)'(term48);
    if (acc_sum > (ACC_W+1)'(ACC_MAX)) acc_new = ACC_MAX;
    else if (acc_sum < (ACC_W+1)'(ACC_MIN)) acc_new = ACC_MIN;
    else acc_new = acc_sum[ACC_W-1:0];
  end

  // largest magnitude
  always_comb begin
    mx = '0;
    for (int i = 0; i < 4; i++)
      if (i < int'(ncomp) && mag[i] > mx) mx = mag[i];
  end

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 48'sh7FFFFFFF) sat32 = 32'h7FFFFFFF;
    else if (v < -48'sh80000000) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  logic [63:0] root_try;
  assign root_try = root_res + root_bit;

  always_comb begin
    alu_ctl.start = 1'b0;
    alu_ctl.op    = OP_NONE;
    alu_a         = '0;
    alu_b         = '0;
    case (state)
      ST_MUL: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op    = OP_MUL;
        alu_a         = 64'(diff_mag);
        alu_b         = 64'(w_mag);
      end
      ST_SQ: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op    = OP_MUL;
        alu_a         = mag[comp];
        alu_b         = mag[comp];
      end
      ST_DIV: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op    = OP_DIV;
        alu_a         = (mag[comp] << FRAC_BITS) + (root_res >> 1);
        alu_b         = root_res;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      for (int i = 0; i < 4; i++) begin
        weight[i] <= '0;
        acc[i]    <= '0;
      end
      enable_mask     <= '0;
      normalize       <= 1'b0;
      component_count <= 3'd3;
      first_item      <= 1'b1;
      m_tvalid        <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        if (cfg_index <= REG_WEIGHT_3) weight[cfg_index[1:0]] <= cfg_data;
        else if (cfg_index == REG_ENABLE) enable_mask <= cfg_data[3:0];
        else if (cfg_index == REG_NORMALIZE) normalize <= cfg_data[0];
        else if (cfg_index == REG_COUNT) component_count <= cfg_data[2:0];
      end
      // the output state reloads the result register itself
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          for (int i = 0; i < 4; i++) begin
            base[i] <= s_tdata[32*i +: 32];
            tgt[i]  <= s_tdata[128 + 32*i +: 32];
            if (first_item) acc[i] <= ACC_W'($signed(s_tdata[32*i +: 32]));
          end
          first_item <= 1'b0;
          slot  <= s_tuser;
          last  <= s_tlast;
          comp  <= '0;
          state <= ST_FIN;
          if (active(s_tuser, enable_mask, weight[s_tuser]))
            state <= ST_MUL;
        end
        ST_MUL: begin
          neg_prod <= diff[32] ^ w_cur[31];
          state    <= ST_MWAIT;
        end
        ST_MWAIT: if (alu_done) begin
          acc[comp] <= acc_new;
          comp      <= comp + 2'd1;
          state     <= (comp == 2'd3) ? ST_FIN : ST_MUL;
        end
        ST_FIN: begin
          if (!last) state <= ST_IDLE;
          else begin
            zero_len <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              res[i] <= (i < int'(ncomp)) ? sat32(acc[i]) : 32'd0;
              mag[i] <= (i < int'(ncomp)) ?
                        (acc[i][ACC_W-1] ? 64'd0 - 64'(acc[i]) : 64'(acc[i])) : 64'd0;
            end
            state <= (any_active && normalize) ? ST_NORM : ST_OUT;
          end
        end
        ST_NORM: begin
          // scale one bit per cycle until max lies in [2^29, 2^30)
          if (mx == 64'd0) begin
            zero_len <= 1'b1;
            for (int i = 0; i < 4; i++) res[i] <= '0;
            state <= ST_OUT;
          end else if (mx >= 64'h40000000) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
          end else if (mx < 64'h20000000) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] << 1;
          end else begin
            comp  <= '0;
            sum   <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_SQW;
        ST_SQW: if (alu_done) begin
          sum  <= sum + alu_res;
          comp <= comp + 2'd1;
          if (comp == 2'(ncomp - 3'd1)) begin
            state    <= ST_ROOT;
            root_rem <= sum + alu_res;
            root_res <= '0;
            root_bit <= 64'd1 << 62;
          end else state <= ST_SQ;
        end
        ST_ROOT: begin
          // one bit pair per cycle
          if (root_bit == 64'd0) begin
            comp  <= '0;
            state <= ST_DIV;
          end else begin
            if (root_rem >= root_try) begin
              root_rem <= root_rem - root_try;
              root_res <= (root_res >> 1) + root_bit;
            end else root_res <= root_res >> 1;
            root_bit <= root_bit >> 2;
          end
        end
        ST_DIV: state <= ST_DWAIT;
        ST_DWAIT: if (alu_done) begin
          res[comp] <= acc[comp][ACC_W-1] ? 32'(-alu_res) : alu_res[31:0];
          comp <= comp + 2'd1;
          state <= (comp == 2'(ncomp - 3'd1)) ? ST_OUT : ST_DIV;
        end
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {res[3], res[2], res[1], res[0]};
          m_tuser  <= zero_len;
          for (int i = 0; i < 4; i++) acc[i] <= '0;
          first_item <= 1'b1;
          state <= ST_IDLE;
        end
        ST_HOLD: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result is only raised from the output state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT)) else $error("stray result");
  // no request accepted while working
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("ready while busy");
  // zero flag only with zero data
  a_zl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 128'd0)) else $error("zero flag data");
endmodule
`default_nettype wire
